// ----- design/assert_macros.svh -----
// assertion macros used by jsm_datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/jsm_pkg.sv -----
// shared types for the script minifier: commands from the controller
// and status back from the datapath; no dependencies
package jsm_pkg;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_FEED,
      OP_FIN,
      OP_MARK,
      OP_DRAIN
   } jsm_op_type;

   typedef struct packed {
      jsm_op_type op;
   } jsm_cmd_type;

   typedef struct packed {
      logic room;
      logic drain_room;
      logic step_more;
      logic step_ccc;
      logic rp_pend;
      logic fin_done;
      logic drain_end;
      logic last;
   } jsm_status_type;

endpackage

// ----- design/jsm_datapath.sv -----
// minifier datapath: scanner state, lookahead, comment store and result queue
// depends on jsm_pkg and assert_macros.svh
`include "assert_macros.svh"

module jsm_datapath import jsm_pkg::*; #(
   parameter int COMMENT_DEPTH = 48
) (
   input  logic           clock,
   input  logic           reset,
   input  jsm_cmd_type    cmd,
   output jsm_status_type st,
   input  logic [7:0]     req_in_byte,
   input  logic           req_in_last,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_byte_valid,
   output logic           rsp_out_last,
   output logic           rsp_failed
);

   localparam int CW = $clog2(COMMENT_DEPTH + 1);
   localparam int AW = $clog2(COMMENT_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(COMMENT_DEPTH);

   localparam logic [8:0] TOK_START  = 9'd256;
   localparam logic [8:0] TOK_NAME   = 9'd257;
   localparam logic [8:0] TOK_CCC    = 9'd258;
   localparam logic [8:0] TOK_REGEX  = 9'd259;
   localparam logic [8:0] TOK_STRING = 9'd260;

   localparam logic [1:0] WS_NONE  = 2'd0;
   localparam logic [1:0] WS_SPACE = 2'd1;
   localparam logic [1:0] WS_BREAK = 2'd2;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_BS    = 8'h5C;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_RBRC  = 8'h7D;

   typedef enum logic [3:0] {
      M_NORMAL,
      M_PSLASH,
      M_PLT,
      M_PDASH,
      M_LINE,
      M_BOPEN,
      M_BPLAIN,
      M_BCCC,
      M_STRING,
      M_REGEX,
      M_HALTED
   } mode_type;

   typedef struct packed {
      logic [1:0]      sc;
      logic [8:0]      tok;
      logic [1:0]      n;
      logic [2:0][7:0] e;
   } emit_type;

   typedef struct packed {
      logic [7:0] data;
      logic       bv;
      logic       last;
      logic       fail;
   } word_type;

   function automatic logic is_ident(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h30 && b <= 8'h39) ||
             (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F || b == 8'h24 ||
             b == CH_BS || b >= 8'h7F;
   endfunction

   function automatic logic no_break(input logic [8:0] t);
      return t inside {TOK_START, 9'h03D, 9'h03C, 9'h03E, 9'h03B, 9'h03A, 9'h03F,
                       9'h07C, 9'h026, 9'h05E, 9'h02A, 9'h02F, 9'h021, 9'h02C,
                       9'h028, 9'h05B, 9'h07B};
   endfunction

   function automatic logic is_div(input logic [8:0] t);
      return t == TOK_NAME || t == TOK_REGEX || t == TOK_STRING ||
             t == {1'b0, CH_RPAR} || t == {1'b0, CH_RBRK};
   endfunction

   function automatic emit_type push(input emit_type s, input logic [7:0] b);
      emit_type r;
      r = s;
      r.e[r.n] = b;
      r.n = r.n + 2'd1;
      return r;
   endfunction

   function automatic emit_type space_if(input emit_type s);
      emit_type r;
      r = s;
      if (r.sc == WS_SPACE) begin
         r = push(r, CH_SP);
      end else if (r.sc == WS_BREAK) begin
         r = push(r, CH_NL);
      end
      r.sc = WS_NONE;
      return r;
   endfunction

   function automatic emit_type change_tok(input emit_type s, input logic [8:0] t);
      emit_type r;
      r = s;
      if (r.sc == WS_BREAK && !no_break(r.tok) && t != {1'b0, CH_RPAR} &&
          t != {1'b0, CH_RBRK} && t != {1'b0, CH_RBRC}) begin
         r = push(r, CH_NL);
      end
      r.sc = WS_NONE;
      r.tok = t;
      return r;
   endfunction

   function automatic emit_type put_op(input emit_type s, input logic [7:0] c);
      emit_type r;
      r = s;
      if ((r.tok == {1'b0, c} && (c == CH_PLUS || c == CH_DASH)) ||
          (r.tok == {1'b0, CH_LT} && c == CH_BANG) ||
          (r.tok == {1'b0, CH_BANG} && c == CH_DASH)) begin
         r = space_if(r);
      end
      r = change_tok(r, {1'b0, c});
      r = push(r, c);
      return r;
   endfunction

   logic [1:0]    sc_ff;
   logic [8:0]    tok_ff;
   mode_type      mode_ff, mode_in;
   logic          dq_ff, dq_in;
   logic          esc_ff, esc_in;
   logic [7:0]    la_ff [3];
   logic [7:0]    la_in [3];
   logic [1:0]    lac_ff, lac_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    cpb_ff, cpb_in;
   logic [7:0]    pre2_ff, pre2_in;
   logic          err_ff, err_in;
   logic [1:0]    rpc_ff, rpc_in;
   logic [1:0]    rpi_ff, rpi_in;
   logic          curp_ff, curp_in;
   logic [7:0]    cur_ff;
   logic          last_ff;
   logic [CW-1:0] d_ff;
   logic [CW-1:0] dsel_ff;
   logic          dpush_ff;
   logic [7:0]    mem [COMMENT_DEPTH];
   logic [7:0]    mem_q;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [7:0]    x;
   logic          replay;
   logic          refeed;
   logic          ccc;
   logic          pat_hit;
   logic [1:0]    pat_len;
   emit_type      s;

   word_type      q_ff [4];
   logic [1:0]    wp_ff;
   logic [1:0]    rp_ff;
   logic [2:0]    qc_ff;
   logic [1:0]    push_n;
   word_type      pw [3];
   logic          pop;
   logic [7:0]    dbyte;

   always_comb begin
      replay  = rpi_ff < rpc_ff;
      x       = replay ? la_ff[rpi_ff] : cur_ff;
      s       = '{sc: sc_ff, tok: tok_ff, n: 2'd0, e: '0};
      mode_in = mode_ff;
      dq_in   = dq_ff;
      esc_in  = esc_ff;
      la_in   = la_ff;
      lac_in  = lac_ff;
      cnt_in  = cnt_ff;
      cpb_in  = cpb_ff;
      pre2_in = pre2_ff;
      err_in  = err_ff;
      rpc_in  = rpc_ff;
      rpi_in  = replay ? rpi_ff + 2'd1 : rpi_ff;
      refeed  = 1'b0;
      ccc     = 1'b0;
      wr_en   = 1'b0;
      pat_hit = 1'b0;
      pat_len = (mode_ff == M_PLT) ? 2'd3 : 2'd2;
      if (cmd.op == OP_FIN) begin
         if (!err_ff) begin
            case (mode_ff)
               M_PLT, M_PDASH: begin
                  rpc_in  = lac_ff;
                  rpi_in  = 2'd0;
                  lac_in  = 2'd0;
                  mode_in = M_NORMAL;
                  s = put_op(s, (mode_ff == M_PLT) ? CH_LT : CH_DASH);
               end
               M_PSLASH: begin
                  if (is_div(tok_ff)) begin
                     s = change_tok(s, {1'b0, CH_SLASH});
                     s = push(s, CH_SLASH);
                     mode_in = M_NORMAL;
                  end else begin
                     err_in  = 1'b1;
                     mode_in = M_HALTED;
                  end
               end
               M_NORMAL, M_LINE: begin
               end
               default: begin
                  err_in  = 1'b1;
                  mode_in = M_HALTED;
               end
            endcase
         end
      end else if (!err_ff) begin
         case (mode_ff)
            M_NORMAL: begin
               if (x == CH_NL || x == CH_CR) begin
                  s.sc = WS_BREAK;
               end else if (x == CH_SP || x == CH_TAB) begin
                  if (s.sc == WS_NONE) begin
                     s.sc = WS_SPACE;
                  end
               end else if (x == CH_SQ || x == CH_DQ) begin
                  s = change_tok(s, TOK_STRING);
                  s = push(s, x);
                  dq_in   = (x == CH_DQ);
                  esc_in  = 1'b0;
                  mode_in = M_STRING;
               end else if (x == CH_SLASH) begin
                  mode_in = M_PSLASH;
               end else if (is_ident(x)) begin
                  if (tok_ff == TOK_NAME || tok_ff == TOK_REGEX) begin
                     s = space_if(s);
                  end
                  s = change_tok(s, TOK_NAME);
                  s = push(s, x);
               end else if (x == CH_LT) begin
                  lac_in  = 2'd0;
                  mode_in = M_PLT;
               end else if (x == CH_DASH && (sc_ff == WS_BREAK || tok_ff == TOK_START)) begin
                  lac_in  = 2'd0;
                  mode_in = M_PDASH;
               end else begin
                  s = put_op(s, x);
               end
            end
            M_PSLASH: begin
               if (x == CH_SLASH) begin
                  mode_in = M_LINE;
               end else if (x == CH_STAR) begin
                  cnt_in  = CW'(2);
                  cpb_in  = 8'h00;
                  mode_in = M_BOPEN;
               end else begin
                  refeed = 1'b1;
                  if (is_div(tok_ff)) begin
                     s = change_tok(s, {1'b0, CH_SLASH});
                     s = push(s, CH_SLASH);
                     mode_in = M_NORMAL;
                  end else begin
                     if (tok_ff == {1'b0, CH_SLASH}) begin
                        s = space_if(s);
                     end
                     s = change_tok(s, TOK_REGEX);
                     s = push(s, CH_SLASH);
                     esc_in  = 1'b0;
                     mode_in = M_REGEX;
                  end
               end
            end
            M_PLT, M_PDASH: begin
               if (mode_ff == M_PLT) begin
                  pat_hit = (lac_ff == 2'd0 && x == CH_BANG) ||
                            (lac_ff == 2'd1 && x == CH_DASH) ||
                            (lac_ff == 2'd2 && x == CH_DASH);
               end else begin
                  pat_hit = (lac_ff == 2'd0 && x == CH_DASH) ||
                            (lac_ff == 2'd1 && x == CH_GT);
               end
               if (pat_hit) begin
                  la_in[lac_ff] = x;
                  if (lac_ff + 2'd1 == pat_len) begin
                     lac_in  = 2'd0;
                     mode_in = M_LINE;
                  end else begin
                     lac_in = lac_ff + 2'd1;
                  end
               end else begin
                  refeed  = 1'b1;
                  rpc_in  = lac_ff;
                  rpi_in  = 2'd0;
                  lac_in  = 2'd0;
                  mode_in = M_NORMAL;
                  s = put_op(s, (mode_ff == M_PLT) ? CH_LT : CH_DASH);
               end
            end
            M_LINE: begin
               if (x == CH_NL) begin
                  mode_in = M_NORMAL;
                  s.sc    = WS_BREAK;
               end
            end
            M_BOPEN: begin
               if (x == CH_AT) begin
                  cnt_in  = CW'(3);
                  pre2_in = CH_STAR;
                  mode_in = M_BCCC;
               end else begin
                  mode_in = M_BPLAIN;
               end
               cpb_in = x;
            end
            M_BPLAIN: begin
               if (x == CH_SLASH && cpb_ff == CH_STAR) begin
                  s.sc    = WS_SPACE;
                  mode_in = M_NORMAL;
               end else begin
                  cpb_in = x;
               end
            end
            M_BCCC: begin
               if (x == CH_SLASH && cpb_ff == CH_STAR) begin
                  mode_in = M_NORMAL;
                  if (pre2_ff == CH_AT) begin
                     s   = change_tok(s, TOK_CCC);
                     ccc = 1'b1;
                  end else begin
                     s.sc = WS_SPACE;
                  end
               end else if (cnt_ff >= DEPTH_C) begin
                  err_in  = 1'b1;
                  mode_in = M_HALTED;
               end else begin
                  wr_en   = 1'b1;
                  cnt_in  = cnt_ff + CW'(1);
                  pre2_in = cpb_ff;
                  cpb_in  = x;
               end
            end
            M_STRING: begin
               s = push(s, x);
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (x == CH_BS) begin
                  esc_in = 1'b1;
               end else if (x == (dq_ff ? CH_DQ : CH_SQ)) begin
                  mode_in = M_NORMAL;
               end
            end
            M_REGEX: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  s = push(s, x);
               end else if (x == CH_BS) begin
                  esc_in = 1'b1;
                  s = push(s, x);
               end else if (x == CH_SLASH) begin
                  s = push(s, x);
                  mode_in = M_NORMAL;
               end else if (x == CH_NL) begin
                  err_in  = 1'b1;
                  mode_in = M_HALTED;
               end else begin
                  s = push(s, x);
               end
            end
            default: begin
            end
         endcase
      end
      curp_in = replay ? curp_ff : refeed;
   end

   assign rd_addr = (d_ff < DEPTH_C) ? d_ff[AW-1:0] : '0;

   always_comb begin
      st.room       = qc_ff <= 3'd1;
      st.drain_room = ({1'b0, qc_ff} + {3'd0, dpush_ff}) <= 4'd3;
      st.step_more  = (rpi_in < rpc_in) || curp_in;
      st.step_ccc   = ccc;
      st.rp_pend    = replay;
      st.fin_done   = err_ff || mode_ff == M_NORMAL || mode_ff == M_LINE;
      st.drain_end  = d_ff == cnt_ff;
      st.last       = last_ff;
   end

   always_comb begin
      if (dsel_ff == CW'(0) || dsel_ff == cnt_ff) begin
         dbyte = CH_SLASH;
      end else if (dsel_ff == CW'(1)) begin
         dbyte = CH_STAR;
      end else if (dsel_ff == CW'(2)) begin
         dbyte = CH_AT;
      end else begin
         dbyte = mem_q;
      end
   end

   always_comb begin
      push_n = 2'd0;
      for (int j = 0; j < 3; j++) begin
         pw[j] = '{data: s.e[j], bv: 1'b1, last: 1'b0, fail: 1'b0};
      end
      if (cmd.op == OP_FEED || cmd.op == OP_FIN) begin
         push_n = s.n;
      end else if (cmd.op == OP_MARK) begin
         push_n = 2'd1;
         pw[0]  = '{data: 8'h00, bv: 1'b0, last: 1'b1, fail: err_ff};
      end else if (dpush_ff) begin
         push_n = 2'd1;
         pw[0]  = '{data: dbyte, bv: 1'b1, last: 1'b0, fail: 1'b0};
      end
   end

   assign pop            = rsp_valid && !rsp_stall;
   assign rsp_valid      = qc_ff != 3'd0;
   assign rsp_out_byte   = q_ff[rp_ff].data;
   assign rsp_byte_valid = q_ff[rp_ff].bv;
   assign rsp_out_last   = q_ff[rp_ff].last;
   assign rsp_failed     = q_ff[rp_ff].fail;

   always_ff @(posedge clock) begin
      if (reset || cmd.op == OP_MARK) begin
         sc_ff   <= WS_NONE;
         tok_ff  <= TOK_START;
         mode_ff <= M_NORMAL;
         dq_ff   <= 1'b0;
         esc_ff  <= 1'b0;
         lac_ff  <= 2'd0;
         cnt_ff  <= '0;
         cpb_ff  <= 8'h00;
         pre2_ff <= 8'h00;
         err_ff  <= 1'b0;
         rpc_ff  <= 2'd0;
         rpi_ff  <= 2'd0;
         curp_ff <= 1'b0;
         last_ff <= 1'b0;
      end else if (cmd.op == OP_ACCEPT) begin
         curp_ff <= 1'b1;
         last_ff <= req_in_last;
      end else if (cmd.op == OP_FEED || cmd.op == OP_FIN) begin
         sc_ff   <= s.sc;
         tok_ff  <= s.tok;
         mode_ff <= mode_in;
         dq_ff   <= dq_in;
         esc_ff  <= esc_in;
         lac_ff  <= lac_in;
         cnt_ff  <= cnt_in;
         cpb_ff  <= cpb_in;
         pre2_ff <= pre2_in;
         err_ff  <= err_in;
         rpc_ff  <= rpc_in;
         rpi_ff  <= rpi_in;
         curp_ff <= curp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         cur_ff <= req_in_byte;
      end
      if (cmd.op == OP_FEED) begin
         la_ff <= la_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_FEED && wr_en) begin
         mem[cnt_ff[AW-1:0]] <= x;
      end
      mem_q   <= mem[rd_addr];
      dsel_ff <= d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff     <= '0;
         dpush_ff <= 1'b0;
      end else begin
         dpush_ff <= cmd.op == OP_DRAIN;
         if (cmd.op == OP_DRAIN) begin
            d_ff <= (d_ff == cnt_ff) ? '0 : d_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (2'(j) < push_n) begin
            q_ff[wp_ff + 2'(j)] <= pw[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 2'd0;
         rp_ff <= 2'd0;
         qc_ff <= 3'd0;
      end else begin
         wp_ff <= wp_ff + push_n;
         rp_ff <= rp_ff + {1'b0, pop};
         qc_ff <= qc_ff + {1'b0, push_n} - {2'd0, pop};
      end
   end

   `ASSERT_IMPLIES(a_step_room, clock, reset, cmd.op == OP_FEED || cmd.op == OP_FIN || cmd.op == OP_MARK, qc_ff <= 3'd1)
   `ASSERT_NEXT(a_mark_clears, clock, reset, cmd.op == OP_MARK, !err_ff && mode_ff == M_NORMAL && qc_ff != 3'd0)
   `ASSERT_NEXT(a_err_sticky, clock, reset, err_ff && cmd.op != OP_MARK, err_ff)

endmodule

// ----- design/jsm_ctrl.sv -----
// minifier controller: sequences accept, scan steps, comment drain and end marker
// depends on jsm_pkg
module jsm_ctrl import jsm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output jsm_cmd_type    cmd,
   input  jsm_status_type st
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_DWAIT,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_stall = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (st.room) begin
               cmd.op = OP_FEED;
               if (st.step_ccc) begin
                  state_in = S_DRAIN;
               end else if (!st.step_more) begin
                  state_in = st.last ? S_FIN : S_IDLE;
               end
            end
         end
         S_DRAIN: begin
            if (st.drain_room) begin
               cmd.op = OP_DRAIN;
               if (st.drain_end) begin
                  state_in = S_DWAIT;
               end
            end
         end
         S_DWAIT: begin
            state_in = st.last ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (st.room) begin
               if (st.rp_pend) begin
                  cmd.op = OP_FEED;
               end else if (st.fin_done) begin
                  cmd.op   = OP_MARK;
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_FIN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/javascript_minifier_stream.sv -----
// Streaming script minifier. A source word is taken in by an accept step and scanned in a
// later feed step once the result queue has room; a byte that resolves a held '/', '<' or '-'
// is scanned again after any replayed lookahead bytes, and the byte marked last adds a short
// end-of-script pass and the end marker. Minified words leave through a four-word queue,
// and scanning waits while that queue holds more than one word. A kept /*@ ... @*/
// comment is replayed from the comment store one word per cycle while the queue has room.
// No clearing pass follows reset.
// depends on jsm_pkg, jsm_ctrl and jsm_datapath
module javascript_minifier_stream import jsm_pkg::*; #(
   parameter int COMMENT_DEPTH = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_out_last,
   output logic       rsp_failed
);

   jsm_cmd_type    cmd;
   jsm_status_type st;

   jsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .st        (st)
   );

   jsm_datapath #(
      .COMMENT_DEPTH (COMMENT_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_last   (rsp_out_last),
      .rsp_failed     (rsp_failed)
   );

endmodule
